### hw/rtl/tile_constraint_propagator_macros.svh
// Assertion macros for the tile constraint propagator.
// Used by tcp_work_queue and tile_constraint_propagator; needs nothing else.
`ifndef TILE_CONSTRAINT_PROPAGATOR_MACROS_SVH
`define TILE_CONSTRAINT_PROPAGATOR_MACROS_SVH

// Property that must hold at every edge out of reset.
`define TCP_ASSERT_HOLDS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tcp: invariant broken");

// Same-cycle implication.
`define TCP_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcp: implication broken");

// Next-cycle implication.
`define TCP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcp: next-cycle check broken");

`endif

### hw/rtl/tcp_pkg.sv
// Shared types, codes and helpers of the tile constraint propagator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tcp_pkg;

   localparam int DIM_W = 11; // holds grid sizes up to 1024

   typedef enum logic [1:0] {
      MODE_COMPAT = 2'd0,
      MODE_WRITE  = 2'd1,
      MODE_PROP   = 2'd2,
      MODE_READ   = 2'd3
   } tcp_mode_type;

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_RIGHT = 2'd3
   } tcp_dir_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_TILES  = 2'd2,
      CSR_NONE   = 2'd3
   } tcp_csr_type;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_START, S_SEED, S_LOOP, S_POP,
      S_CMASK, S_DIR, S_NB, S_SUP, S_ACC, S_UPD
   } tcp_state_type;

   typedef struct packed {
      tcp_mode_type mode;
      logic [4:0]   row;
      logic [4:0]   col;
      tcp_dir_type  direction;
      logic [3:0]   tile_index;
      logic [15:0]  mask;
      logic         collapsed_in;
   } tcp_req_type;

   typedef struct packed {
      logic [15:0] cell_mask;
      logic        cell_collapsed;
      logic [4:0]  cell_entropy;
      logic        consistent;
      logic [11:0] steps_used;
   } tcp_rsp_type;

   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } tcp_q_ctl_type;

   function automatic logic [4:0] popcount16(input logic [15:0] v);
      logic [4:0] c;
      c = '0;
      for (int i = 0; i < 16; i++) begin
         c = c + 5'(v[i]);
      end
      return c;
   endfunction

   function automatic logic [15:0] tiles_mask(input logic [4:0] n);
      logic [16:0] m;
      m = (17'd1 << n) - 17'd1;
      return m[15:0];
   endfunction

endpackage
`default_nettype wire

### hw/rtl/tile_constraint_propagator.sv
// Tile constraint propagator top level: sequencer, cell and compat memories.
// Depends on tcp_pkg, tcp_work_queue and the assertion macro header.
//
//   channel  | ports                               | handshake
//   ---------+-------------------------------------+------------------------------
//   request  | start, busy, req_word               | taken when start & !busy
//   result   | rsp_valid, rsp_word                 | one-cycle strobe, no stall
//   csr      | csr_valid, csr_ready, csr_index/... | written when valid & ready
//
// Compat load and cell write: the word comes out the next cycle and a new request
//   can be taken in that same cycle.
// Cell read: the registered read of the cell memory, then the registered response.
// Propagate: clears the queue, seeds it with the cell, then per queue pop reads the
//   popped mask and, per direction, skips an off-grid or collapsed neighbour or
//   gathers support over the tiles in use and writes its narrowed mask; every step
//   goes through the one cell-memory port and the one compat-memory port in turn.
// Reset (synchronous) empties the queue and sets the grid to 32 x 32, 16 tiles;
//   memories are not cleared. busy is high for the whole of a propagate or read.
`timescale 1ns / 1ps
`default_nettype none
`include "tile_constraint_propagator_macros.svh"
module tile_constraint_propagator #(
   parameter int MAX_TILES   = 16,
   parameter int MAX_WIDTH   = 32,
   parameter int MAX_HEIGHT  = 32,
   parameter int QUEUE_DEPTH = 8192
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  wire tcp_pkg::tcp_req_type req_word,
   output logic                 rsp_valid,
   output tcp_pkg::tcp_rsp_type rsp_word,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire  [1:0]           csr_index,
   input  wire  [5:0]           csr_wdata
);
   localparam int DIM_W    = tcp_pkg::DIM_W;
   localparam int AREA_W   = 2 * DIM_W + 1;
   localparam int RB       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CB       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int QW       = RB + CB;
   localparam int CELLS    = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW       = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CTA      = $clog2(4 * MAX_TILES);
   localparam int ITER_W   = $clog2(2 * CELLS + 1);
   localparam int Q_CW     = $clog2(QUEUE_DEPTH + 1);
   localparam int TILE_LIM = (MAX_TILES < 16) ? MAX_TILES : 16;

   // ---- configuration registers ----
   logic [5:0] width_ff, height_ff;
   logic [4:0] tiles_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 6'd32;
         height_ff <= 6'd32;
         tiles_ff  <= 5'd16;
      end else if (csr_valid && csr_ready) begin
         unique case (tcp_pkg::tcp_csr_type'(csr_index))
            tcp_pkg::CSR_WIDTH:  width_ff  <= csr_wdata;
            tcp_pkg::CSR_HEIGHT: height_ff <= csr_wdata;
            tcp_pkg::CSR_TILES:  tiles_ff  <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // effective grid and tile set: saturated to what the storage holds, zero width or height taken as 1
   logic [DIM_W-1:0] eff_w, eff_h;
   logic [4:0]       eff_n;
   logic [15:0]      tm;

   always_comb begin
      priority if (width_ff == '0) eff_w = DIM_W'(1);
      else if (DIM_W'(width_ff) > DIM_W'(MAX_WIDTH)) eff_w = DIM_W'(MAX_WIDTH);
      else eff_w = DIM_W'(width_ff);
      priority if (height_ff == '0) eff_h = DIM_W'(1);
      else if (DIM_W'(height_ff) > DIM_W'(MAX_HEIGHT)) eff_h = DIM_W'(MAX_HEIGHT);
      else eff_h = DIM_W'(height_ff);
      eff_n = (tiles_ff > 5'(TILE_LIM)) ? 5'(TILE_LIM) : tiles_ff;
      tm    = tcp_pkg::tiles_mask(eff_n);
   end

   function automatic logic [AW-1:0] cell_addr(input logic [RB-1:0] r,
                                                input logic [CB-1:0] c);
      logic [AREA_W-1:0] lin;
      lin = AREA_W'(r) * AREA_W'(MAX_WIDTH) + AREA_W'(c);
      return lin[AW-1:0];
   endfunction

   function automatic logic [CTA-1:0] compat_addr(input logic [1:0] d,
                                                  input logic [4:0] t);
      int lin;
      lin = int'(d) * MAX_TILES + int'(t);
      return CTA'(lin);
   endfunction

   // ---- memories: cell word is {collapsed, mask} ----
   logic [16:0] cell_mem [CELLS];
   logic [15:0] compat_mem [4 * MAX_TILES];
   logic          cell_we, cell_re, compat_we, compat_re;
   logic [AW-1:0] cell_waddr, cell_raddr;
   logic [16:0]   cell_wdata, cell_rdata_ff;
   logic [CTA-1:0] compat_waddr, compat_raddr;
   logic [15:0]   compat_rdata_ff;

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_waddr] <= cell_wdata;
      end
      if (cell_re) begin
         cell_rdata_ff <= cell_mem[cell_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (compat_we) begin
         compat_mem[compat_waddr] <= req_word.mask;
      end
      if (compat_re) begin
         compat_rdata_ff <= compat_mem[compat_raddr];
      end
   end

   // ---- work queue ----
   tcp_pkg::tcp_q_ctl_type q_ctl;
   logic [QW-1:0]   q_push_data, q_pop_data;
   logic [Q_CW-1:0] q_count;

   tcp_work_queue #(
      .DEPTH  (QUEUE_DEPTH),
      .DATA_W (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .q_ctl     (q_ctl),
      .push_data (q_push_data),
      .pop_data  (q_pop_data),
      .count     (q_count)
   );

   // ---- sequencer ----
   tcp_pkg::tcp_state_type state_ff, state_in;
   tcp_pkg::tcp_dir_type   dir_ff, dir_in;
   logic [RB-1:0]     cur_row_ff, cur_row_in, nb_row_ff, nb_row_in;
   logic [CB-1:0]     cur_col_ff, cur_col_in, nb_col_ff, nb_col_in;
   logic [4:0]        t_ff, t_in;
   logic [15:0]       cmask_ff, cmask_in, old_ff, old_in, support_ff, support_in;
   logic [ITER_W-1:0] iter_ff, iter_in, cap_ff, cap_in;
   logic              rsp_valid_ff, rsp_valid_in;
   tcp_pkg::tcp_rsp_type rsp_word_ff, rsp_word_in;

   // request decode
   logic          req_inside;
   logic [RB-1:0] req_r;
   logic [CB-1:0] req_c;
   assign req_inside = (DIM_W'(req_word.row) < eff_h) && (DIM_W'(req_word.col) < eff_w);
   assign req_r      = RB'(req_word.row);
   assign req_c      = CB'(req_word.col);

   // neighbour of the popped cell in the current direction
   logic          nb_ok;
   logic [RB-1:0] nb_r;
   logic [CB-1:0] nb_c;
   always_comb begin
      nb_r = cur_row_ff;
      nb_c = cur_col_ff;
      unique case (dir_ff)
         tcp_pkg::DIR_UP: begin
            nb_ok = cur_row_ff != '0;
            nb_r  = cur_row_ff - RB'(1);
         end
         tcp_pkg::DIR_DOWN: begin
            nb_ok = (DIM_W'(cur_row_ff) + DIM_W'(1)) < eff_h;
            nb_r  = cur_row_ff + RB'(1);
         end
         tcp_pkg::DIR_LEFT: begin
            nb_ok = cur_col_ff != '0;
            nb_c  = cur_col_ff - CB'(1);
         end
         tcp_pkg::DIR_RIGHT: begin
            nb_ok = (DIM_W'(cur_col_ff) + DIM_W'(1)) < eff_w;
            nb_c  = cur_col_ff + CB'(1);
         end
         default: nb_ok = 1'b0;
      endcase
   end

   logic [AREA_W-1:0] area_x2;
   logic [15:0]       upd;
   assign area_x2 = (AREA_W'(eff_w) * AREA_W'(eff_h)) << 1;
   assign upd     = old_ff & ((support_ff & tm) | ~tm);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcp_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff      <= dir_in;
      cur_row_ff  <= cur_row_in;
      cur_col_ff  <= cur_col_in;
      nb_row_ff   <= nb_row_in;
      nb_col_ff   <= nb_col_in;
      t_ff        <= t_in;
      cmask_ff    <= cmask_in;
      old_ff      <= old_in;
      support_ff  <= support_in;
      iter_ff     <= iter_in;
      cap_ff      <= cap_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_comb begin
      state_in     = state_ff;
      dir_in       = dir_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      nb_row_in    = nb_row_ff;
      nb_col_in    = nb_col_ff;
      t_in         = t_ff;
      cmask_in     = cmask_ff;
      old_in       = old_ff;
      support_in   = support_ff;
      iter_in      = iter_ff;
      cap_in       = cap_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;
      cell_we      = 1'b0;
      cell_waddr   = cell_addr(nb_row_ff, nb_col_ff);
      cell_wdata   = {1'b0, upd};
      cell_re      = 1'b0;
      cell_raddr   = cell_addr(req_r, req_c);
      compat_we    = 1'b0;
      compat_waddr = compat_addr(req_word.direction, {1'b0, req_word.tile_index});
      compat_re    = 1'b0;
      compat_raddr = compat_addr(dir_ff, t_ff);
      q_ctl        = '0;
      q_push_data  = {nb_row_ff, nb_col_ff};

      unique case (state_ff)
         tcp_pkg::S_IDLE: begin
            if (start) begin
               rsp_word_in = '0;
               unique case (req_word.mode)
                  tcp_pkg::MODE_COMPAT: begin
                     compat_we    = int'(req_word.tile_index) < MAX_TILES;
                     rsp_valid_in = 1'b1;
                  end
                  tcp_pkg::MODE_WRITE: begin
                     cell_we      = req_inside;
                     cell_waddr   = cell_addr(req_r, req_c);
                     cell_wdata   = {req_word.collapsed_in, req_word.mask};
                     rsp_valid_in = 1'b1;
                  end
                  tcp_pkg::MODE_PROP: begin
                     if (req_inside) begin
                        cur_row_in = req_r;
                        cur_col_in = req_c;
                        state_in   = tcp_pkg::S_START;
                     end else begin
                        rsp_word_in.consistent = 1'b1;
                        rsp_valid_in           = 1'b1;
                     end
                  end
                  tcp_pkg::MODE_READ: begin
                     if (req_inside) begin
                        cell_re  = 1'b1;
                        state_in = tcp_pkg::S_READ;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         tcp_pkg::S_READ: begin
            rsp_word_in                = '0;
            rsp_word_in.cell_mask      = cell_rdata_ff[15:0];
            rsp_word_in.cell_collapsed = cell_rdata_ff[16];
            rsp_word_in.cell_entropy   = tcp_pkg::popcount16(cell_rdata_ff[15:0] & tm);
            rsp_valid_in               = 1'b1;
            state_in                   = tcp_pkg::S_IDLE;
         end
         tcp_pkg::S_START: begin
            q_ctl.clear = 1'b1;
            iter_in     = '0;
            cap_in      = ITER_W'(area_x2);
            state_in    = tcp_pkg::S_SEED;
         end
         tcp_pkg::S_SEED: begin
            q_ctl.push  = 1'b1;
            q_push_data = {cur_row_ff, cur_col_ff};
            state_in    = tcp_pkg::S_LOOP;
         end
         tcp_pkg::S_LOOP: begin
            if ((q_count != '0) && (iter_ff < cap_ff)) begin
               q_ctl.pop = 1'b1;
               state_in  = tcp_pkg::S_POP;
            end else begin
               rsp_word_in            = '0;
               rsp_word_in.consistent = 1'b1;
               rsp_word_in.steps_used = 12'(iter_ff);
               rsp_valid_in           = 1'b1;
               state_in               = tcp_pkg::S_IDLE;
            end
         end
         tcp_pkg::S_POP: begin
            cur_row_in = q_pop_data[QW-1:CB];
            cur_col_in = q_pop_data[CB-1:0];
            iter_in    = iter_ff + ITER_W'(1);
            cell_re    = 1'b1;
            cell_raddr = cell_addr(q_pop_data[QW-1:CB], q_pop_data[CB-1:0]);
            state_in   = tcp_pkg::S_CMASK;
         end
         tcp_pkg::S_CMASK: begin
            cmask_in = cell_rdata_ff[15:0] & tm;
            dir_in   = tcp_pkg::DIR_UP;
            state_in = tcp_pkg::S_DIR;
         end
         tcp_pkg::S_DIR: begin
            if (nb_ok) begin
               nb_row_in  = nb_r;
               nb_col_in  = nb_c;
               cell_re    = 1'b1;
               cell_raddr = cell_addr(nb_r, nb_c);
               state_in   = tcp_pkg::S_NB;
            end else if (dir_ff == tcp_pkg::DIR_RIGHT) begin
               state_in = tcp_pkg::S_LOOP;
            end else begin
               dir_in = tcp_pkg::tcp_dir_type'(2'(dir_ff + 2'd1));
            end
         end
         tcp_pkg::S_NB: begin
            if (cell_rdata_ff[16]) begin
               // collapsed neighbour is left alone
               if (dir_ff == tcp_pkg::DIR_RIGHT) begin
                  state_in = tcp_pkg::S_LOOP;
               end else begin
                  dir_in   = tcp_pkg::tcp_dir_type'(2'(dir_ff + 2'd1));
                  state_in = tcp_pkg::S_DIR;
               end
            end else begin
               old_in     = cell_rdata_ff[15:0];
               support_in = '0;
               t_in       = '0;
               state_in   = tcp_pkg::S_SUP;
            end
         end
         tcp_pkg::S_SUP: begin
            if (t_ff == eff_n) begin
               state_in = tcp_pkg::S_UPD;
            end else if (cmask_ff[t_ff[3:0]]) begin
               compat_re = 1'b1;
               state_in  = tcp_pkg::S_ACC;
            end else begin
               t_in = t_ff + 5'd1;
            end
         end
         tcp_pkg::S_ACC: begin
            support_in = support_ff | compat_rdata_ff;
            t_in       = t_ff + 5'd1;
            state_in   = tcp_pkg::S_SUP;
         end
         tcp_pkg::S_UPD: begin
            cell_we = 1'b1;
            if ((upd & tm) == '0) begin
               // contradiction: the emptied mask stays written
               rsp_word_in            = '0;
               rsp_word_in.steps_used = 12'(iter_ff);
               rsp_valid_in           = 1'b1;
               state_in               = tcp_pkg::S_IDLE;
            end else begin
               q_ctl.push = upd != old_ff;
               if (dir_ff == tcp_pkg::DIR_RIGHT) begin
                  state_in = tcp_pkg::S_LOOP;
               end else begin
                  dir_in   = tcp_pkg::tcp_dir_type'(2'(dir_ff + 2'd1));
                  state_in = tcp_pkg::S_DIR;
               end
            end
         end
         default: state_in = tcp_pkg::S_IDLE;
      endcase
   end

   assign busy      = state_ff != tcp_pkg::S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // propagate taken from an in-grid cell
   logic prop_take;
   logic in_acc;
   assign prop_take = start && !busy && req_inside && (req_word.mode == tcp_pkg::MODE_PROP);
   assign in_acc    = state_ff == tcp_pkg::S_ACC;

   `TCP_ASSERT_IMPLIES(a_rsp_in_idle, clock, reset, rsp_valid_ff, state_ff == tcp_pkg::S_IDLE)
   `TCP_ASSERT_IMPLIES(a_acc_bit_set, clock, reset, in_acc, cmask_ff[t_ff[3:0]])
   `TCP_ASSERT_NEXT(a_prop_goes_busy, clock, reset, prop_take, busy && !rsp_valid_ff)

endmodule
`default_nettype wire

### hw/rtl/tcp_work_queue.sv
// Circular work queue of cell coordinates, one memory, registered pop data.
// Depends on tcp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "tile_constraint_propagator_macros.svh"
module tcp_work_queue #(
   parameter int DEPTH  = 8192,
   parameter int DATA_W = 10
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire tcp_pkg::tcp_q_ctl_type q_ctl,
   input  wire  [DATA_W-1:0]          push_data,
   output logic [DATA_W-1:0]          pop_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [PW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [DATA_W-1:0] pop_data_ff;
   logic full, do_push, do_pop;

   assign full    = count_ff == CW'(DEPTH);
   assign do_push = q_ctl.push && !full && !q_ctl.clear; // full queue drops the push
   assign do_pop  = q_ctl.pop && (count_ff != '0) && !q_ctl.clear;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (q_ctl.clear) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end else begin
         if (do_push) begin
            tail_in = (tail_ff == PW'(DEPTH - 1)) ? '0 : tail_ff + PW'(1);
         end
         if (do_pop) begin
            head_in = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + PW'(1);
         end
         count_in = count_ff + CW'(do_push) - CW'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[tail_ff] <= push_data;
      end
      if (do_pop) begin
         pop_data_ff <= mem[head_ff];
      end
   end

   assign pop_data = pop_data_ff;
   assign count    = count_ff;

   `TCP_ASSERT_HOLDS(a_q_bound, clock, reset, count_ff <= CW'(DEPTH))
   `TCP_ASSERT_IMPLIES(a_q_no_underflow, clock, reset, q_ctl.pop, count_ff != '0)
   `TCP_ASSERT_NEXT(a_q_clear, clock, reset, q_ctl.clear, count_ff == '0)

endmodule
`default_nettype wire
